// ----- hw/rtl/dce_pkg.sv -----
// Shared types and constants for the digit combination enumerator.
// Used by the controller, the datapath and the top level; no dependencies.
package dce_pkg;

    // ASCII codes and digit range
    localparam logic [5:0] DIGIT_BASE = 6'd48;
    localparam logic [5:0] CHR_COMMA  = 6'd44;
    localparam logic [5:0] CHR_SPACE  = 6'd32;
    localparam logic [4:0] NUM_DIGITS = 5'd10;

    // Size register width and its value after reset
    localparam int         SIZE_W     = 4;
    localparam logic [3:0] SIZE_RESET = 4'd2;

    // Width of the character counter (digits plus comma and space)
    localparam int         CNT_W      = 4;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } dce_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // reload first combination
        logic advance;   // step to next combination
        logic clr_cnt;   // restart character counter
        logic emit;      // load output word, bump counter
    } dce_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fin;        // current combination is the final one
        logic char_last;  // counter points at the last character
    } dce_stat_t;

endpackage

// ----- hw/rtl/dce_tick_if.sv -----
// Input channel: one tick word carrying the restart flag.
// Standalone interface; no dependencies.
interface dce_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// ----- hw/rtl/dce_char_if.sv -----
// Output channel: one character word per handshake.
// Standalone interface; no dependencies.
interface dce_char_if;
    logic       valid;
    logic       ready;
    logic [5:0] char_code;
    logic       last_char;
    logic       final_combo;

    modport source (output valid, output char_code, output last_char, output final_combo,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input final_combo,
                    output ready);
endinterface

// ----- hw/rtl/dce_dpath.sv -----
// Datapath: size register, digit position lanes, character counter, output payload.
// Depends on dce_pkg; driven by dce_ctrl through dce_cmd_t.
module dce_dpath
    import dce_pkg::*;
#(
    parameter int DEPTH = 9
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  dce_cmd_t          cmd,
    output dce_stat_t         stat,
    output logic [5:0]        char_code,
    output logic              last_char,
    output logic              final_combo
);

    localparam int         IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [3:0] DEPTH_V = 4'(DEPTH);

    logic [SIZE_W-1:0] size_reg;
    logic [3:0]        pos_reg  [DEPTH];
    logic [3:0]        pos_next [DEPTH];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [5:0]        char_reg;
    logic              last_reg;
    logic              fin_reg;

    logic [3:0]        n;
    logic [4:0]        lim   [DEPTH];
    logic [DEPTH-1:0]  grow;
    logic              fin;
    logic              piv_found;
    logic [IDX_W-1:0]  piv_idx;
    logic [3:0]        piv_val;
    logic [5:0]        char_sel;
    logic              last_sel;

    // Clamp size into 1..DEPTH
    always_comb
    begin
        if (size_reg == '0)
            n = 4'd1;
        else if (size_reg > DEPTH_V)
            n = DEPTH_V;
        else
            n = size_reg;
    end

    // Per-lane limit compare, final check, rightmost growable lane
    always_comb
    begin
        fin       = 1'b1;
        piv_found = 1'b0;
        piv_idx   = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            lim[k]  = NUM_DIGITS - {1'b0, n} + 5'(k);
            grow[k] = (4'(k) < n) && ({1'b0, pos_reg[k]} < lim[k]);
            if ((4'(k) < n) && ({1'b0, pos_reg[k]} != lim[k]))
                fin = 1'b0;
            if (grow[k])
            begin
                piv_found = 1'b1;
                piv_idx   = IDX_W'(k);
            end
        end
        piv_val = pos_reg[piv_idx];
    end

    // Next digit positions: reload or advance with consecutive refill
    always_comb
    begin
        for (int j = 0; j < DEPTH; j++)
        begin
            pos_next[j] = pos_reg[j];
            if (cmd.load)
                pos_next[j] = 4'(j);
            else if (cmd.advance && piv_found && (IDX_W'(j) >= piv_idx))
                pos_next[j] = 4'(5'({1'b0, piv_val}) + 5'd1 + 5'(j) - 5'(piv_idx));
        end
    end

    // Select the character at the counter
    always_comb
    begin
        if (cnt_reg < n)
            char_sel = DIGIT_BASE + {2'b00, pos_reg[cnt_reg[IDX_W-1:0]]};
        else if (cnt_reg == n)
            char_sel = CHR_COMMA;
        else
            char_sel = CHR_SPACE;
        if (fin)
            last_sel = (cnt_reg == n - 4'd1);
        else
            last_sel = (cnt_reg == n + 4'd1);
    end

    // Advance the character counter
    always_comb
    begin
        priority if (cmd.clr_cnt)
            cnt_next = '0;
        else if (cmd.emit)
            cnt_next = cnt_reg + CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    // Hold size, lanes and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            cnt_reg  <= '0;
            for (int k = 0; k < DEPTH; k++)
                pos_reg[k] <= 4'(k);
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_wdata;
            cnt_reg <= cnt_next;
            for (int k = 0; k < DEPTH; k++)
                pos_reg[k] <= pos_next[k];
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= char_sel;
            last_reg <= last_sel;
            fin_reg  <= fin;
        end
    end

    assign stat.fin       = fin;
    assign stat.char_last = last_sel;
    assign char_code      = char_reg;
    assign last_char      = last_reg;
    assign final_combo    = fin_reg;

endmodule

// ----- hw/rtl/dce_ctrl.sv -----
// Controller: tick acceptance, started/exhausted flags, output valid and emit sequencing.
// Depends on dce_pkg; commands dce_dpath through dce_cmd_t.
module dce_ctrl
    import dce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      tick_valid,
    input  logic      tick_restart,
    output logic      tick_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output dce_cmd_t  cmd,
    input  dce_stat_t stat
);

    dce_state_t state_reg, state_next;
    logic       started_reg, started_next;
    logic       exhausted_reg, exhausted_next;
    logic       valid_reg, valid_next;

    // Hold state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            exhausted_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            exhausted_reg <= exhausted_next;
            valid_reg     <= valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        exhausted_next = exhausted_reg;
        valid_next     = valid_reg && !out_ready;
        cmd            = '0;
        tick_ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                if (tick_valid)
                begin
                    priority if (tick_restart || !started_reg)
                    begin
                        cmd.load       = 1'b1;
                        cmd.clr_cnt    = 1'b1;
                        started_next   = 1'b1;
                        exhausted_next = 1'b0;
                        state_next     = ST_EMIT;
                    end
                    else if (!exhausted_reg)
                    begin
                        cmd.advance = 1'b1;
                        cmd.clr_cnt = 1'b1;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        // drop the tick, nothing left to emit
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    if (stat.char_last)
                    begin
                        if (stat.fin)
                            exhausted_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A size write restarts the enumeration
        if (cfg_we)
        begin
            started_next   = 1'b0;
            exhausted_next = 1'b0;
        end
    end

    assign out_valid = valid_reg;

endmodule

// ----- hw/rtl/digit_combination_enumerator.sv -----
// Top level of the digit combination enumerator: ties controller and datapath.
// Depends on dce_pkg, dce_tick_if, dce_char_if, dce_ctrl and dce_dpath.
//
//   channel   dir  payload                                 per word
//   tick      in   restart                                 one tick
//   chars     out  char_code[5:0], last_char, final_combo  one character
//   cfg_*     in   cfg_wdata[3:0] = combo_size             one write
//
// A tick is taken in the idle state; the block then emits n digits plus comma
// and space (n digits only on the final combination), one character per cycle
// while the output is not stalled, and returns to idle after the last
// character to take the next tick. A tick after the final combination is
// taken and emits nothing. Reset sets combo_size to 2 and restarts the
// enumeration; a stalled output holds the sequence in place.
module digit_combination_enumerator
    import dce_pkg::*;
#(
    parameter int MAX_SIZE = 9
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    dce_tick_if.sink          tick,
    dce_char_if.source        chars
);

    localparam int DEPTH = (MAX_SIZE < 10) ? MAX_SIZE : 10;

    dce_cmd_t  cmd;
    dce_stat_t stat;

    // Sequence ticks and character words
    dce_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .tick_valid   (tick.valid),
        .tick_restart (tick.restart),
        .tick_ready   (tick.ready),
        .out_valid    (chars.valid),
        .out_ready    (chars.ready),
        .cmd          (cmd),
        .stat         (stat)
    );

    // Hold digits and build characters
    dce_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .stat        (stat),
        .char_code   (chars.char_code),
        .last_char   (chars.last_char),
        .final_combo (chars.final_combo)
    );

endmodule

// ----- tb/dce_checker.sv -----
`timescale 1ns / 100ps
// Checker for the digit combination enumerator: predicts every character word
// from the size register and the accepted ticks, and compares it on the output.
// Depends on dce_pkg only; it watches plain signals wired up by the testbench top.
module dce_checker
    import dce_pkg::*;
#(
    parameter int MAX_SIZE = 9
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              tick_valid,
    input  logic              tick_ready,
    input  logic              tick_restart,
    input  logic              char_valid,
    input  logic              char_ready,
    input  logic [5:0]        char_code,
    input  logic              last_char,
    input  logic              final_combo,
    output int                pending,
    output int                errors
);

    typedef struct packed {
        logic [5:0] code;
        logic       last;
        logic       fin;
    } char_word_t;

    // Predicted enumerator state
    logic [3:0]        combo_digits [MAX_SIZE];
    logic [SIZE_W-1:0] size_reg;
    logic              started;
    logic              exhausted;

    char_word_t        char_q [$];
    int                err_cnt;

    // Map the raw size register onto the digit count actually used
    function automatic int digit_count(logic [SIZE_W-1:0] raw);
        int n;
        n = raw;
        if (n < 1)
            n = 1;
        if (n > MAX_SIZE)
            n = MAX_SIZE;
        return n;
    endfunction

    // Step the combination for one tick and queue the characters it emits
    function automatic void predict_combo(logic restart);
        int         n;
        int         k;
        int         j;
        logic       fin;
        char_word_t w;

        n = digit_count(size_reg);
        if (restart || !started)
        begin
            for (k = 0; k < n; k++)
                combo_digits[k] = k[3:0];
            started   = 1'b1;
            exhausted = 1'b0;
        end
        else if (exhausted)
            return;
        else
        begin
            // bump the rightmost digit with room left, refill the tail consecutively
            for (k = n - 1; k >= 0; k--)
            begin
                if (combo_digits[k] < 10 - n + k)
                begin
                    combo_digits[k] = combo_digits[k] + 4'd1;
                    for (j = k + 1; j < n; j++)
                        combo_digits[j] = combo_digits[j - 1] + 4'd1;
                    break;
                end
            end
        end

        // final combination is the top n digits
        fin = 1'b1;
        for (k = 0; k < n; k++)
            if (combo_digits[k] != 10 - n + k)
                fin = 1'b0;
        if (fin)
            exhausted = 1'b1;

        for (k = 0; k < n; k++)
        begin
            w.code = DIGIT_BASE + 6'(combo_digits[k]);
            w.last = fin && (k == n - 1);
            w.fin  = fin;
            char_q.push_back(w);
        end
        if (!fin)
        begin
            w = '{code: CHR_COMMA, last: 1'b0, fin: 1'b0};
            char_q.push_back(w);
            w = '{code: CHR_SPACE, last: 1'b1, fin: 1'b0};
            char_q.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        char_word_t want;
        char_word_t got;
        int         k;

        if (!rst_n)
        begin
            for (k = 0; k < MAX_SIZE; k++)
                combo_digits[k] = k[3:0];
            size_reg  = SIZE_RESET;
            started   = 1'b0;
            exhausted = 1'b0;
            char_q.delete();
            err_cnt   = 0;
            pending  <= 0;
            errors   <= 0;
        end
        else
        begin
            // a size write restarts the enumeration
            if (cfg_we)
            begin
                size_reg  = cfg_wdata;
                started   = 1'b0;
                exhausted = 1'b0;
            end

            // compare each accepted character word with the oldest prediction
            if (char_valid && char_ready)
            begin
                got = '{code: char_code, last: last_char, fin: final_combo};
                if (char_q.size() == 0)
                begin
                    $display("%0t: unexpected char code %0d last %0b final %0b",
                             $time, got.code, got.last, got.fin);
                    err_cnt++;
                end
                else
                begin
                    want = char_q.pop_front();
                    if (got.code !== want.code || got.last !== want.last ||
                        got.fin !== want.fin)
                    begin
                        $display("%0t: char mismatch: expected code %0d last %0b final %0b,",
                                 $time, want.code, want.last, want.fin);
                        $display("%0t:                actual code %0d last %0b final %0b",
                                 $time, got.code, got.last, got.fin);
                        err_cnt++;
                    end
                end
            end

            if (tick_valid && tick_ready)
                predict_combo(tick_restart);

            pending <= char_q.size();
            errors  <= err_cnt;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the digit combination enumerator: drives ticks, size writes
// and output back-pressure, and gives the verdict. Depends on dce_pkg, the two
// channel interfaces, digit_combination_enumerator and dce_checker.
module tb;
    import dce_pkg::*;

    localparam int MAX_SIZE      = 9;
    localparam int TICK_TARGET   = 360;
    localparam int SETTLE_CYCLES = 20;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    int send_idle_pct = 9;
    int recv_idle_pct = 71;
    int pending;
    int errors;
    int sent;
    int seg_len;
    int combos;
    int n;
    int k;
    logic [SIZE_W-1:0] sz;

    dce_tick_if tick ();
    dce_char_if chars ();

    digit_combination_enumerator #(.MAX_SIZE(MAX_SIZE)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tick      (tick),
        .chars     (chars)
    );

    dce_checker #(.MAX_SIZE(MAX_SIZE)) combo_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .tick_valid   (tick.valid),
        .tick_ready   (tick.ready),
        .tick_restart (tick.restart),
        .char_valid   (chars.valid),
        .char_ready   (chars.ready),
        .char_code    (chars.char_code),
        .last_char    (chars.last_char),
        .final_combo  (chars.final_combo),
        .pending      (pending),
        .errors       (errors)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stall the character channel at random
    initial
    begin
        chars.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            chars.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offer one tick word, idling first at random, and hold until it is taken
    task automatic send_tick(input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        tick.valid   <= 1'b1;
        tick.restart <= restart;
        @(posedge clk);
        while (!tick.ready)
            @(posedge clk);
    endtask

    // Drop valid and hold until every predicted character has come out
    task automatic wait_idle();
        tick.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        tick.valid   <= 1'b0;
        tick.restart <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset size: first tick with restart low still starts at the first combination
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);

        // single digits: run past the final combination, then restart
        wait_idle();
        write_size(4'd1);
        repeat (11) send_tick(1'b0);
        send_tick(1'b1);

        // size zero acts as one, oversize acts as the maximum
        wait_idle();
        write_size(4'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        wait_idle();
        write_size(4'd15);
        send_tick(1'b0);
        send_tick(1'b1);

        // random segments, each at a fresh size, mostly advancing toward the end
        sent = 0;
        while (sent < TICK_TARGET)
        begin
            if (sent >= 2 * TICK_TARGET / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sent >= TICK_TARGET / 3)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 9;
            end
            wait_idle();

            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 3))
                    0:       sz = 4'd1;
                    1:       sz = 4'd2;
                    2:       sz = 4'd8;
                    default: sz = 4'd9;
                endcase
            end
            else
                sz = SIZE_W'($urandom_range(0, 15));
            write_size(sz);

            // segment length tracks how many combinations this size has
            n = (sz == 0) ? 1 : ((sz > MAX_SIZE) ? MAX_SIZE : sz);
            combos = 1;
            for (k = 0; k < n; k++)
                combos = combos * (10 - k) / (k + 1);
            seg_len = $urandom_range(5, ((combos < 50) ? combos : 50) + 2);
            repeat (seg_len)
            begin
                send_tick($urandom_range(0, 39) == 0);
                sent++;
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
